FILE: src/udf_pkg.sv
// Shared constants and types for the unsigned decimal formatter.
// Used by the front end, the descriptor queue, the back end and the top level.
// No dependencies.
package udf_pkg;

    localparam int MAX_FIELD = 64;
    localparam int BIN_W     = 32;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int STEP_W    = $clog2(BIN_W);
    localparam int CNT_W     = $clog2(MAX_FIELD + 1);
    localparam int LEN_W     = $clog2(DIGITS + 1);
    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // One formatted field: digits plus the counts of each run of characters.
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [LEN_W-1:0] num_digits;
        logic [CNT_W-1:0] num_zeros;
        logic [CNT_W-1:0] num_pad;
        logic             left;
    } t_desc;

endpackage

FILE: src/udf_front.sv
// Front end: accepts a value beat, converts it to BCD one bit per cycle and
// classifies the field into pad, zero and digit runs. Depends on udf_pkg.
module udf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [udf_pkg::BIN_W-1:0]  i_value,
    input  logic [udf_pkg::CNT_W-1:0]  i_field_width,
    input  logic [7:0]                 i_min_digits,
    input  logic                       i_zero_pad,
    input  logic                       i_left_align,
    output logic                       o_push_valid,
    input  logic                       i_push_ready,
    output udf_pkg::t_desc             o_push_desc
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    logic [udf_pkg::STEP_W-1:0]     r_step, n_step;
    logic [udf_pkg::BIN_W-1:0]      r_bin, n_bin;
    logic [udf_pkg::BCD_W-1:0]      r_bcd, n_bcd;
    logic [udf_pkg::CNT_W-1:0]      r_width, n_width;
    logic [7:0]                     r_prec_raw, n_prec_raw;
    logic                           r_zpad, n_zpad;
    logic                           r_left, n_left;

    logic [udf_pkg::BCD_W-1:0]      adj_bcd;
    logic [udf_pkg::LEN_W-1:0]      len;
    logic [udf_pkg::CNT_W-1:0]      width_sat;
    logic [udf_pkg::CNT_W-1:0]      prec;
    logic [udf_pkg::CNT_W-1:0]      prec_fin;
    logic [udf_pkg::CNT_W-1:0]      len_ext;

    // Add three to every digit of five or more ahead of the shift.
    always_comb begin
        for (int d = 0; d < udf_pkg::DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // Digit count: position of the highest non-zero digit, zero counts as one.
    always_comb begin
        len = udf_pkg::LEN_W'(1);
        for (int d = 1; d < udf_pkg::DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                len = udf_pkg::LEN_W'(d + 1);
            end
        end
    end

    always_comb begin
        len_ext = udf_pkg::CNT_W'(len);
        if (r_width > udf_pkg::CNT_W'(udf_pkg::MAX_FIELD)) begin
            width_sat = udf_pkg::CNT_W'(udf_pkg::MAX_FIELD);
        end else begin
            width_sat = r_width;
        end
        if (!r_prec_raw[7]) begin
            if (r_prec_raw[6:0] > 7'(udf_pkg::MAX_FIELD)) begin
                prec = udf_pkg::CNT_W'(udf_pkg::MAX_FIELD);
            end else begin
                prec = udf_pkg::CNT_W'(r_prec_raw[6:0]);
            end
        end else if (r_zpad) begin
            prec = width_sat;
        end else begin
            prec = '0;
        end
        prec_fin = (prec < len_ext) ? len_ext : prec;

        o_push_desc.bcd        = r_bcd;
        o_push_desc.num_digits = len;
        o_push_desc.num_zeros  = prec_fin - len_ext;
        o_push_desc.num_pad    = (prec_fin < width_sat) ? (width_sat - prec_fin) : '0;
        o_push_desc.left       = r_left;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_push_valid = (r_state == ST_PUSH);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_bin      = r_bin;
        n_bcd      = r_bcd;
        n_width    = r_width;
        n_prec_raw = r_prec_raw;
        n_zpad     = r_zpad;
        n_left     = r_left;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_bin      = i_value;
                    n_bcd      = '0;
                    n_step     = '0;
                    n_width    = i_field_width;
                    n_prec_raw = i_min_digits;
                    n_zpad     = i_zero_pad;
                    n_left     = i_left_align;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd  = {adj_bcd[udf_pkg::BCD_W-2:0], r_bin[udf_pkg::BIN_W-1]};
                n_bin  = {r_bin[udf_pkg::BIN_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == udf_pkg::STEP_W'(udf_pkg::BIN_W - 1)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_push_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step     <= n_step;
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_width    <= n_width;
        r_prec_raw <= n_prec_raw;
        r_zpad     <= n_zpad;
        r_left     <= n_left;
    end

endmodule

FILE: src/udf_queue.sv
// Two-entry descriptor queue between the front end and the back end.
// Depends on udf_pkg for the descriptor type and depth.
module udf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  udf_pkg::t_desc i_push_desc,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output udf_pkg::t_desc o_pop_desc
);

    udf_pkg::t_desc              r_mem [udf_pkg::Q_DEPTH];
    logic [udf_pkg::QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [udf_pkg::QCNT_W-1:0]  r_count;
    logic                        push, pop;

    assign o_push_ready = (r_count != udf_pkg::QCNT_W'(udf_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_desc   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

FILE: src/udf_back.sv
// Back end: takes one descriptor at a time and emits its characters one per
// cycle while the output is not stalled, through an output register. Depends on udf_pkg.
module udf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  udf_pkg::t_desc i_pop_desc,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_last
);

    logic                          r_active, n_active;
    logic [udf_pkg::BCD_W-1:0]     r_bcd, n_bcd;
    logic [udf_pkg::LEN_W-1:0]     r_dig, n_dig;
    logic [udf_pkg::CNT_W-1:0]     r_zero, n_zero;
    logic [udf_pkg::CNT_W-1:0]     r_pad, n_pad;
    logic                          r_left, n_left;
    logic                          r_out_valid, n_out_valid;
    logic [7:0]                    r_out_char, n_out_char;
    logic                          r_out_last, n_out_last;
    logic                          adv;
    logic [udf_pkg::LEN_W-1:0]     dig_idx;

    assign o_pop_ready = !r_active;
    assign adv         = !r_out_valid || i_ready;
    assign dig_idx     = r_dig - 1'b1;

    always_comb begin
        n_active    = r_active;
        n_bcd       = r_bcd;
        n_dig       = r_dig;
        n_zero      = r_zero;
        n_pad       = r_pad;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (!r_active && i_pop_valid) begin
            n_active = 1'b1;
            n_bcd    = i_pop_desc.bcd;
            n_dig    = i_pop_desc.num_digits;
            n_zero   = i_pop_desc.num_zeros;
            n_pad    = i_pop_desc.num_pad;
            n_left   = i_pop_desc.left;
        end

        if (adv) begin
            n_out_valid = 1'b0;
            if (r_active) begin
                n_out_valid = 1'b1;
                if (!r_left && r_pad != '0) begin
                    n_out_char = udf_pkg::CHAR_SPACE;
                    n_pad      = r_pad - 1'b1;
                end else if (r_zero != '0) begin
                    n_out_char = udf_pkg::CHAR_ZERO;
                    n_zero     = r_zero - 1'b1;
                end else if (r_dig != '0) begin
                    n_out_char = udf_pkg::CHAR_ZERO + {4'd0, r_bcd[dig_idx*4 +: 4]};
                    n_dig      = r_dig - 1'b1;
                end else begin
                    // trailing spaces of a left-aligned field
                    n_out_char = udf_pkg::CHAR_SPACE;
                    n_pad      = r_pad - 1'b1;
                end
                n_out_last = (n_pad == '0) && (n_zero == '0) && (n_dig == '0);
                if (n_out_last) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_bcd      <= n_bcd;
        r_dig      <= n_dig;
        r_zero     <= n_zero;
        r_pad      <= n_pad;
        r_left     <= n_left;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

FILE: src/unsigned_decimal_formatter_core.sv
// Unsigned decimal formatter: value beat in, run of ASCII character beats out.
// Path from input beat to first character: bit-serial BCD conversion,
// classify and push into the descriptor queue, back-end load, output reg.
// Throughput: one character per cycle while the receiver is ready; a new value
// is taken only once the last one is pushed, so conversion overlaps emission.
// Reset: synchronous active-low clears handshake state; no clearing pass.
module unsigned_decimal_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // value[31:0], field_width[38:32], min_digits[46:39], bit 47 unused
    input  logic [47:0] i_s_axis_tdata,
    // zero_pad[0], left_align[1]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_char[7:0]
    output logic [7:0]  o_m_axis_tdata,
    // last_char
    output logic        o_m_axis_tlast
);

    logic           push_valid, push_ready;
    udf_pkg::t_desc push_desc;
    logic           pop_valid, pop_ready;
    udf_pkg::t_desc pop_desc;

    udf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_value       (i_s_axis_tdata[31:0]),
        .i_field_width (i_s_axis_tdata[38:32]),
        .i_min_digits  (i_s_axis_tdata[46:39]),
        .i_zero_pad    (i_s_axis_tuser[0]),
        .i_left_align  (i_s_axis_tuser[1]),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_desc   (push_desc)
    );

    udf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_desc  (push_desc),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_desc   (pop_desc)
    );

    udf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_desc  (pop_desc),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

FILE: sim/unsigned_decimal_formatter_core_tb.sv
// Self-checking testbench for unsigned_decimal_formatter_core: value beats in,
// ASCII character beats out, compared against an in-bench model of the field.
// Depends on udf_pkg and the core RTL only.
module unsigned_decimal_formatter_core_tb;

    localparam int CYCLE       = 20;
    localparam int RAND_FIELDS = 360;
    localparam int DIR_N       = 23;
    localparam int DRAIN_LIMIT = 40000;
    localparam int TAIL_CYCLES = 100;

    localparam logic [7:0] PREC_NONE = 8'hFF;

    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SPARSE = 2;

    typedef struct packed {
        logic [31:0] value;
        logic [6:0]  width;
        logic [7:0]  prec;
        logic        zpad;
        logic        left;
    } t_fmt_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;
    logic        m_last;

    t_char_beat  pending_chars[$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          rx_mode = RX_OPEN;
    int          rx_left = 0;
    int          rx_phase = 0;

    unsigned_decimal_formatter_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // value[31:0], field_width[38:32], min_digits[46:39], bit 47 unused
        .i_s_axis_tdata  (s_data),
        // zero_pad[0], left_align[1]
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // out_char[7:0]
        .o_m_axis_tdata  (m_data),
        // last_char
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        forever #(CYCLE / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CYCLE * 1000000);
        $display("** unsigned_decimal_formatter_core: FAILED **");
        $finish;
    end

    // Directed rows; an empty text means the field is worked out by format_field.
    localparam t_fmt_item DIR_ITEMS [DIR_N] = '{
        '{32'd0,          7'd0,   PREC_NONE, 1'b0, 1'b0},
        '{32'd0,          7'd0,   8'd0,      1'b0, 1'b0},
        '{32'hFFFFFFFF,   7'd0,   PREC_NONE, 1'b0, 1'b0},
        '{32'h80000000,   7'd0,   PREC_NONE, 1'b0, 1'b0},
        '{32'h80000001,   7'd0,   PREC_NONE, 1'b0, 1'b0},
        '{32'd7,          7'd5,   PREC_NONE, 1'b0, 1'b0},
        '{32'd7,          7'd5,   PREC_NONE, 1'b0, 1'b1},
        '{32'd7,          7'd5,   PREC_NONE, 1'b1, 1'b0},
        '{32'd7,          7'd5,   8'd3,      1'b0, 1'b0},
        '{32'd7,          7'd5,   8'd3,      1'b1, 1'b0},
        '{32'd7,          7'd5,   8'd3,      1'b0, 1'b1},
        '{32'd42,         7'd127, PREC_NONE, 1'b0, 1'b0},
        '{32'd42,         7'd0,   8'd127,    1'b0, 1'b0},
        '{32'd42,         7'd100, 8'h80,     1'b1, 1'b0},
        '{32'd42,         7'd3,   8'hFE,     1'b0, 1'b0},
        '{32'd1234567890, 7'd12,  PREC_NONE, 1'b0, 1'b1},
        '{32'd9,          7'd64,  8'd64,     1'b0, 1'b0},
        '{32'd123,        7'd2,   8'd1,      1'b0, 1'b0},
        '{32'd0,          7'd4,   PREC_NONE, 1'b1, 1'b0},
        '{32'd0,          7'd64,  PREC_NONE, 1'b1, 1'b1},
        '{32'hFFFFFFFF,   7'd64,  PREC_NONE, 1'b0, 1'b1},
        '{32'd10,         7'd0,   PREC_NONE, 1'b0, 1'b0},
        '{32'd99999,      7'd7,   8'd6,      1'b1, 1'b1}
    };

    string dir_text [DIR_N];

    // Queue the characters of one formatted field, last one marked.
    task automatic format_field(input t_fmt_item it);
        logic [3:0]  dig [udf_pkg::DIGITS];
        logic [31:0] v;
        int          w;
        int          p;
        int          len;
        int          pad;
        int          total;
        int          k;
        int          i;
        bit          prec_given;
        v = it.value;
        w = int'(it.width);
        prec_given = !it.prec[7];
        p = prec_given ? int'(it.prec) : -1;
        if (w > udf_pkg::MAX_FIELD) w = udf_pkg::MAX_FIELD;
        if (p > udf_pkg::MAX_FIELD) p = udf_pkg::MAX_FIELD;
        len = 0;
        do begin
            dig[len] = 4'(v % 32'd10);
            v = v / 32'd10;
            len++;
        end while (v != 0);
        if (it.zpad && !prec_given) p = w;
        if (p < len) p = len;
        pad = (p < w) ? w - p : 0;
        total = p + pad;
        k = 0;
        if (!it.left) begin
            for (i = 0; i < pad; i++, k++) begin
                pending_chars.push_back('{udf_pkg::CHAR_SPACE, k == total - 1});
            end
        end
        for (i = 0; i < p - len; i++, k++) begin
            pending_chars.push_back('{udf_pkg::CHAR_ZERO, k == total - 1});
        end
        for (i = len - 1; i >= 0; i--, k++) begin
            pending_chars.push_back('{udf_pkg::CHAR_ZERO + 8'(dig[i]), k == total - 1});
        end
        if (it.left) begin
            for (i = 0; i < pad; i++, k++) begin
                pending_chars.push_back('{udf_pkg::CHAR_SPACE, k == total - 1});
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_field(input t_fmt_item it, input string text);
        int gap;
        int i;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 90) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, it.prec, it.width, it.value};
        s_user  <= {it.left, it.zpad};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (text.len() == 0) begin
            format_field(it);
        end else begin
            for (i = 0; i < text.len(); i++) begin
                pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
            end
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        longint unsigned p;
        int              k;
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 99));
            // either side of a decade edge
            1: return 32'(p) - 32'($urandom_range(0, 1));
            2: return 32'hFFFFFFFF - 32'($urandom_range(0, 3));
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_fmt_item rand_item();
        t_fmt_item it;
        it.value = rand_value();
        it.width = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, 16));
        case ($urandom_range(0, 4))
            0, 1: it.prec = PREC_NONE;
            2: it.prec = 8'($urandom_range(128, 255));
            3: it.prec = 8'($urandom_range(0, 16));
            default: it.prec = 8'($urandom_range(0, 255));
        endcase
        it.zpad = 1'($urandom_range(0, 1));
        it.left = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Receiver: stall in modes of random length.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_SPARSE);
            rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            default: begin
                rx_phase++;
                m_ready <= (rx_phase % 4 == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin : char_check
        t_char_beat want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: character beat with nothing pending: char %h last %b",
                         $time, m_data, m_last);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_data !== want.ch) begin
                    $display("%0t: char mismatch: expected %h, actual %h",
                             $time, want.ch, m_data);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int n;
        int waited;
        dir_text = '{"0", "0", "4294967295", "2147483648", "2147483649",
                     "    7", "7    ", "00007", "  007", "  007", "007  ",
                     "", "", "", " 42", "1234567890  ", "", "123", "0000",
                     "", "", "10", "099999 "};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (n = 0; n < DIR_N; n++) send_field(DIR_ITEMS[n], dir_text[n]);
        for (n = 0; n < RAND_FIELDS; n++) send_field(rand_item(), "");
        s_valid <= 1'b0;

        waited = 0;
        while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d character beats never arrived, next expected %h last %b",
                     $time, pending_chars.size(), pending_chars[0].ch, pending_chars[0].last);
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("** unsigned_decimal_formatter_core: PASSED **");
        end else begin
            $display("** unsigned_decimal_formatter_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
src/udf_pkg.sv
src/udf_front.sv
src/udf_queue.sv
src/udf_back.sv
src/unsigned_decimal_formatter_core.sv
sim/unsigned_decimal_formatter_core_tb.sv
